@@ rtl/core/necir_pkg.sv @@
// shared constants, codes and types for the nec ir pulse decoder
package necir_pkg;

   // frame geometry
   localparam int unsigned FRAME_BITS = 32;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned WIDTH_W    = 16;
   localparam int unsigned CNT_W      = 6;
   localparam logic [CNT_W-1:0] FRAME_BITS_CNT = CNT_W'(FRAME_BITS);

   // timing windows in 1 us ticks, inclusive
   localparam logic [WIDTH_W-1:0] LEAD_LOW_MIN  = 16'd7200;
   localparam logic [WIDTH_W-1:0] LEAD_LOW_MAX  = 16'd10800;
   localparam logic [WIDTH_W-1:0] LEAD_HIGH_MIN = 16'd3600;
   localparam logic [WIDTH_W-1:0] LEAD_HIGH_MAX = 16'd5400;
   localparam logic [WIDTH_W-1:0] LONG_MIN      = 16'd1800;
   localparam logic [WIDTH_W-1:0] LONG_MAX      = 16'd2700;
   localparam logic [WIDTH_W-1:0] SHORT_MIN     = 16'd896;
   localparam logic [WIDTH_W-1:0] SHORT_MAX     = 16'd1344;

   // request codes
   localparam logic REQ_EDGE  = 1'b0;
   localparam logic REQ_RESET = 1'b1;

   // decoder state codes
   localparam int unsigned STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [STATE_W-1:0] ST_LEAD_LOW  = 3'd1;
   localparam logic [STATE_W-1:0] ST_LEAD_HIGH = 3'd2;
   localparam logic [STATE_W-1:0] ST_DATA      = 3'd3;
   localparam logic [STATE_W-1:0] ST_STOP      = 3'd4;

   // window comparator hits for one pulse width
   typedef struct packed {
      logic lead_low;
      logic lead_high;
      logic long_gap;
      logic short_gap;
   } window_hit_type;

   // one result transfer
   typedef struct packed {
      logic              frame_done;
      logic [WORD_W-1:0] frame_data;
      logic              format_error;
      logic              capture_rising;
   } result_type;

endpackage

@@ rtl/core/necir_window.sv @@
// window comparators that classify one pulse width
module necir_window (
   input  logic [necir_pkg::WIDTH_W-1:0] pulse_width,
   output necir_pkg::window_hit_type     hit
);

   always_comb begin
      hit.lead_low  = (pulse_width >= necir_pkg::LEAD_LOW_MIN)
                   && (pulse_width <= necir_pkg::LEAD_LOW_MAX);
      hit.lead_high = (pulse_width >= necir_pkg::LEAD_HIGH_MIN)
                   && (pulse_width <= necir_pkg::LEAD_HIGH_MAX);
      // also serves as the repeat gap and the data one window
      hit.long_gap  = (pulse_width >= necir_pkg::LONG_MIN)
                   && (pulse_width <= necir_pkg::LONG_MAX);
      hit.short_gap = (pulse_width >= necir_pkg::SHORT_MIN)
                   && (pulse_width <= necir_pkg::SHORT_MAX);
   end

endmodule

@@ rtl/core/necir_fsm.sv @@
// frame state machine, bit counter and shift word
module necir_fsm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       req_kind,
   input  logic                       line_level,
   input  necir_pkg::window_hit_type  hit,
   output necir_pkg::result_type      result
);

   logic [necir_pkg::STATE_W-1:0] state_ff, state_in;
   logic [necir_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [necir_pkg::WORD_W-1:0]  shift_ff, shift_in;
   logic                          edge_ff, edge_in;
   logic [necir_pkg::CNT_W-1:0]   cnt_inc;

   assign cnt_inc = cnt_ff + necir_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      edge_in  = edge_ff;
      result   = '0;
      if (req_kind == necir_pkg::REQ_RESET) begin
         state_in = necir_pkg::ST_IDLE;
         cnt_in   = '0;
         shift_in = '0;
         edge_in  = 1'b0;
      end else begin
         unique case (state_ff)
            necir_pkg::ST_LEAD_LOW: begin
               if (line_level) begin
                  edge_in = 1'b0;
                  if (hit.lead_low) begin
                     state_in = necir_pkg::ST_LEAD_HIGH;
                  end else begin
                     result.format_error = 1'b1;
                     cnt_in   = '0;
                     state_in = necir_pkg::ST_IDLE;
                  end
               end
            end
            necir_pkg::ST_LEAD_HIGH: begin
               if (!line_level) begin
                  if (hit.lead_high) begin
                     state_in = necir_pkg::ST_DATA;
                     edge_in  = 1'b0;
                  end else if (hit.long_gap) begin
                     // repeat leader
                     state_in = necir_pkg::ST_STOP;
                     edge_in  = 1'b1;
                  end else begin
                     result.format_error = 1'b1;
                     cnt_in   = '0;
                     edge_in  = 1'b0;
                     state_in = necir_pkg::ST_IDLE;
                  end
               end
            end
            necir_pkg::ST_DATA: begin
               if (!line_level) begin
                  if (hit.short_gap || hit.long_gap) begin
                     // lsb first: new bit enters at the top
                     shift_in = {hit.long_gap && !hit.short_gap,
                                 shift_ff[necir_pkg::WORD_W-1:1]};
                     cnt_in   = cnt_inc;
                     if (cnt_inc == necir_pkg::FRAME_BITS_CNT) begin
                        state_in = necir_pkg::ST_STOP;
                        edge_in  = 1'b1;
                     end
                  end else begin
                     result.format_error = 1'b1;
                     cnt_in   = '0;
                     edge_in  = 1'b0;
                     state_in = necir_pkg::ST_IDLE;
                  end
               end
            end
            necir_pkg::ST_STOP: begin
               if (line_level) begin
                  result.frame_done = 1'b1;
                  result.frame_data = shift_ff;
                  cnt_in   = '0;
                  state_in = necir_pkg::ST_IDLE;
                  edge_in  = 1'b0;
               end
            end
            default: begin
               // idle and unused codes
               if (!line_level) begin
                  edge_in  = 1'b1;
                  state_in = necir_pkg::ST_LEAD_LOW;
               end
            end
         endcase
      end
      result.capture_rising = edge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= necir_pkg::ST_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         edge_ff  <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         edge_ff  <= edge_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_edge_rising_states: assert property (@(posedge clock) disable iff (reset)
      (state_ff == necir_pkg::ST_LEAD_LOW || state_ff == necir_pkg::ST_STOP) |-> edge_ff)
      else $error("edge select low in a state that waits for a rising edge");

   a_edge_falling_states: assert property (@(posedge clock) disable iff (reset)
      (state_ff == necir_pkg::ST_IDLE || state_ff == necir_pkg::ST_LEAD_HIGH
       || state_ff == necir_pkg::ST_DATA) |-> !edge_ff)
      else $error("edge select high in a state that waits for a falling edge");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= necir_pkg::FRAME_BITS_CNT)
      else $error("bit counter ran past the frame length");

   a_idle_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == necir_pkg::ST_LEAD_LOW) |-> (cnt_ff == '0))
      else $error("bit counter not cleared at frame start");
`endif

endmodule

@@ rtl/core/nec_ir_pulse_decoder.sv @@
// top level of the nec ir pulse decoder: input register, state machine, result register
//
// usage
//   request channel: one transfer per captured ir edge (req_type edge) carrying the
//   width in 1 us ticks since the previous edge and the line level after it, or a
//   decoder reset request (req_type reset) that clears all frame state
//   response channel: exactly one transfer per request, in order, with frame_done,
//   the 32-bit word (zero unless frame_done), format_error and capture_rising,
//   the edge polarity the capture unit should look for next
//   path: a request goes through the input register, then the result register,
//   whose contents drive the response channel
//   throughput: one request per cycle while rsp_stall is low; the state machine and
//   window comparators sit between the input and result registers, so nothing iterates
//   stalls: a stalled response holds in the result register while the input
//   register still takes one more request; req_stall rises only when both hold
//   an item and rsp_stall is high
//   reset: synchronous, clears both registers' valid flags and puts the decoder
//   in idle with a zero word, waiting for a falling edge
module nec_ir_pulse_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [necir_pkg::WIDTH_W-1:0]     req_pulse_width,
   input  logic                              req_line_level,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_frame_done,
   output logic [necir_pkg::WORD_W-1:0]      rsp_frame_data,
   output logic                              rsp_format_error,
   output logic                              rsp_capture_rising
);

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_kind_ff;
   logic [necir_pkg::WIDTH_W-1:0] in_width_ff;
   logic                          in_level_ff;

   // result register
   logic                          out_valid_ff, out_valid_in;
   necir_pkg::result_type         out_ff;

   logic                          out_ready;
   logic                          advance;
   logic                          req_take;
   necir_pkg::window_hit_type     hit;
   necir_pkg::result_type         result;

   // result register is free when empty or being drained this cycle
   assign out_ready = !out_valid_ff || !rsp_stall;
   // item moves from input register to result register, state commits
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_type;
         in_width_ff <= req_pulse_width;
         in_level_ff <= req_line_level;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // width classification
   necir_window u_window (
      .pulse_width (in_width_ff),
      .hit         (hit)
   );

   // frame state machine, commits only when the item moves on
   necir_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .req_kind   (in_kind_ff),
      .line_level (in_level_ff),
      .hit        (hit),
      .result     (result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_data     = out_ff.frame_data;
   assign rsp_format_error   = out_ff.format_error;
   assign rsp_capture_rising = out_ff.capture_rising;

`ifndef NO_ASSERTIONS
   a_done_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_done && rsp_format_error))
      else $error("frame done and format error on the same transfer");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (rsp_frame_data == '0))
      else $error("nonzero word without frame done");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled while a register is free");

   a_done_falling_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_done || rsp_format_error)) |-> !rsp_capture_rising)
      else $error("decoder not back on falling edge after frame end or error");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the nec ir pulse decoder
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import necir_pkg::*;

   // the random part stops once about this many edge transfers went in
   localparam int unsigned ITEM_TARGET   = 2000;
   // chance in a hundred that a side idles on a given cycle
   localparam int unsigned GAP_PERCENT   = 17;
   // long receiver hold-off, long enough to fill both decoder registers
   localparam int unsigned HOLD_CYCLES   = 80;
   // cycles without any transfer before the run is declared hung
   localparam int unsigned HANG_LIMIT    = 2000;
   // drain time after the last response
   localparam int unsigned DRAIN_CYCLES  = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_type;
   logic [WIDTH_W-1:0]   req_pulse_width;
   logic                 req_line_level;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_frame_done;
   logic [WORD_W-1:0]    rsp_frame_data;
   logic                 rsp_format_error;
   logic                 rsp_capture_rising;

   nec_ir_pulse_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_pulse_width    (req_pulse_width),
      .req_line_level     (req_line_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_data     (rsp_frame_data),
      .rsp_format_error   (rsp_format_error),
      .rsp_capture_rising (rsp_capture_rising)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // decoder predictor: its own copy of the frame state
   // ---------------------------------------------------------------------------
   logic [STATE_W-1:0] ir_state;
   logic [CNT_W-1:0]   ir_bit_count;
   logic [WORD_W-1:0]  ir_word;
   logic               ir_rising_next;

   // responses still owed by the decoder, oldest first
   result_type decoded_frames [$];

   int unsigned mismatch_count;
   int unsigned edges_sent;
   bit          gaps_on;
   bit          hold_request;
   int unsigned hang_cycles;

   function automatic bit in_range(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] lo,
                                   logic [WIDTH_W-1:0] hi);
      return (w >= lo) && (w <= hi);
   endfunction

   // bad width: back to idle, word kept
   function automatic void abandon_frame();
      ir_bit_count   = '0;
      ir_rising_next = 1'b0;
      ir_state       = ST_IDLE;
   endfunction

   // data bits enter at the top so the first bit ends lowest
   function automatic void shift_in(logic one);
      ir_word      = {one, ir_word[WORD_W-1:1]};
      ir_bit_count = ir_bit_count + 1'b1;
      if (ir_bit_count == FRAME_BITS_CNT) begin
         ir_state       = ST_STOP;
         ir_rising_next = 1'b1;
      end
   endfunction

   function automatic result_type decode_edge(logic kind, logic [WIDTH_W-1:0] w, logic lvl);
      result_type r;
      r = '0;
      if (kind == REQ_RESET) begin
         ir_state       = ST_IDLE;
         ir_bit_count   = '0;
         ir_word        = '0;
         ir_rising_next = 1'b0;
      end else begin
         case (ir_state)
            ST_LEAD_LOW: begin
               // carrier on for the leader, ends on a rising edge
               if (lvl) begin
                  ir_rising_next = 1'b0;
                  if (in_range(w, LEAD_LOW_MIN, LEAD_LOW_MAX)) begin
                     ir_state = ST_LEAD_HIGH;
                  end else begin
                     r.format_error = 1'b1;
                     abandon_frame();
                  end
               end
            end
            ST_LEAD_HIGH: begin
               // full gap opens a frame, short gap means repeat
               if (!lvl) begin
                  if (in_range(w, LEAD_HIGH_MIN, LEAD_HIGH_MAX)) begin
                     ir_state       = ST_DATA;
                     ir_rising_next = 1'b0;
                  end else if (in_range(w, LONG_MIN, LONG_MAX)) begin
                     ir_state       = ST_STOP;
                     ir_rising_next = 1'b1;
                  end else begin
                     r.format_error = 1'b1;
                     abandon_frame();
                  end
               end
            end
            ST_DATA: begin
               if (!lvl) begin
                  if (in_range(w, SHORT_MIN, SHORT_MAX)) begin
                     shift_in(1'b0);
                  end else if (in_range(w, LONG_MIN, LONG_MAX)) begin
                     shift_in(1'b1);
                  end else begin
                     r.format_error = 1'b1;
                     abandon_frame();
                  end
               end
            end
            ST_STOP: begin
               // stop carrier ends: hand out the held word
               if (lvl) begin
                  r.frame_done   = 1'b1;
                  r.frame_data   = ir_word;
                  ir_bit_count   = '0;
                  ir_state       = ST_IDLE;
                  ir_rising_next = 1'b0;
               end
            end
            default: begin
               if (!lvl) begin
                  ir_rising_next = 1'b1;
                  ir_state       = ST_LEAD_LOW;
               end
            end
         endcase
      end
      r.capture_rising = ir_rising_next;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // directed table: typed expectations only where obvious
   // ---------------------------------------------------------------------------
   typedef struct packed {
      logic               kind;
      logic [WIDTH_W-1:0] width;
      logic               level;
      bit                 typed;
      result_type         want;
   } stim_row_type;

   localparam result_type QUIET       = '0;
   localparam result_type BAD_WIDTH   = {1'b0, 32'd0, 1'b1, 1'b0};
   localparam result_type ZERO_REPEAT = {1'b1, 32'd0, 1'b0, 1'b0};
   localparam int unsigned DIRECTED_N = 30;

   stim_row_type directed_rows [DIRECTED_N] = '{
      '{REQ_RESET, 16'd0,     1'b0, 1'b1, QUIET},        // decoder reset request
      '{REQ_EDGE,  16'd65535, 1'b1, 1'b1, QUIET},        // idle ignores a rising edge
      '{REQ_EDGE,  16'd0,     1'b0, 1'b0, QUIET},        // leader carrier starts
      '{REQ_EDGE,  16'd500,   1'b0, 1'b0, QUIET},        // wrong level in leader low
      '{REQ_EDGE,  16'd7199,  1'b1, 1'b1, BAD_WIDTH},    // leader one tick short
      '{REQ_EDGE,  16'd0,     1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd10800, 1'b1, 1'b0, QUIET},        // leader at its longest
      '{REQ_EDGE,  16'd2700,  1'b0, 1'b0, QUIET},        // repeat gap at its longest
      '{REQ_EDGE,  16'd1000,  1'b0, 1'b0, QUIET},        // stop ignores a falling edge
      '{REQ_EDGE,  16'd0,     1'b1, 1'b1, ZERO_REPEAT},  // repeat right after reset
      '{REQ_EDGE,  16'd65535, 1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd7200,  1'b1, 1'b0, QUIET},        // leader at its shortest
      '{REQ_EDGE,  16'd1799,  1'b0, 1'b1, BAD_WIDTH},    // gap below the repeat window
      '{REQ_EDGE,  16'd1,     1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd10801, 1'b1, 1'b1, BAD_WIDTH},    // leader one tick long
      '{REQ_EDGE,  16'd0,     1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd9000,  1'b1, 1'b0, QUIET},
      '{REQ_EDGE,  16'd5401,  1'b0, 1'b1, BAD_WIDTH},    // frame gap one tick long
      '{REQ_EDGE,  16'd0,     1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd9000,  1'b1, 1'b0, QUIET},
      '{REQ_EDGE,  16'd3600,  1'b0, 1'b0, QUIET},        // frame gap at its shortest
      '{REQ_EDGE,  16'd896,   1'b0, 1'b0, QUIET},        // zero bit, shortest
      '{REQ_EDGE,  16'd2700,  1'b1, 1'b0, QUIET},        // data ignores a rising edge
      '{REQ_EDGE,  16'd1800,  1'b0, 1'b0, QUIET},        // one bit, shortest
      '{REQ_EDGE,  16'd1344,  1'b0, 1'b0, QUIET},        // zero bit, longest
      '{REQ_EDGE,  16'd1345,  1'b0, 1'b1, BAD_WIDTH},    // bit period between windows
      '{REQ_EDGE,  16'd0,     1'b0, 1'b0, QUIET},
      '{REQ_EDGE,  16'd9000,  1'b1, 1'b0, QUIET},
      '{REQ_EDGE,  16'd1800,  1'b0, 1'b0, QUIET},        // repeat gap at its shortest
      '{REQ_EDGE,  16'd65535, 1'b1, 1'b0, QUIET}         // repeat hands out the partial word
   };

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic offer(input logic kind, input logic [WIDTH_W-1:0] w, input logic lvl,
                        input bit typed, input result_type typed_want);
      result_type predicted;
      while (gaps_on && ($urandom_range(99) < GAP_PERCENT)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_type        = kind;
      req_pulse_width = w;
      req_line_level  = lvl;
      // hold the payload until the decoder takes it
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predicted = decode_edge(kind, w, lvl);
      decoded_frames.push_back(typed ? typed_want : predicted);
      edges_sent++;
      @(negedge clock);
   endtask

   task automatic offer_edge(input logic [WIDTH_W-1:0] w, input logic lvl);
      offer(REQ_EDGE, w, lvl, 1'b0, QUIET);
   endtask

   // in-window width, edges of the window often
   function automatic logic [WIDTH_W-1:0] pick_in(logic [WIDTH_W-1:0] lo,
                                                  logic [WIDTH_W-1:0] hi);
      case ($urandom_range(3))
         0:       return lo;
         1:       return hi;
         default: return WIDTH_W'($urandom_range(int'(hi), int'(lo)));
      endcase
   endfunction

   // width that misses the window, and every other window of that state too
   function automatic logic [WIDTH_W-1:0] pick_out(logic [WIDTH_W-1:0] lo,
                                                   logic [WIDTH_W-1:0] hi);
      case ($urandom_range(3))
         0:       return lo - 1'b1;
         1:       return hi + 1'b1;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // one frame or repeat; break_at > 0 spoils that edge and drops the rest
   //   1 leader low, 2 leader gap, 3.. data bits
   task automatic send_frame(input bit is_repeat, input int break_at);
      logic [WORD_W-1:0]  payload;
      logic [WIDTH_W-1:0] lo;
      logic [WIDTH_W-1:0] hi;
      int                 k;
      payload = $urandom;
      offer_edge(WIDTH_W'($urandom_range(65535)), 1'b0);
      if ($urandom_range(19) == 0) offer_edge(WIDTH_W'($urandom_range(65535)), 1'b0);
      if (break_at == 1) begin
         offer_edge(pick_out(LEAD_LOW_MIN, LEAD_LOW_MAX), 1'b1);
         return;
      end
      offer_edge(pick_in(LEAD_LOW_MIN, LEAD_LOW_MAX), 1'b1);
      lo = is_repeat ? LONG_MIN : LEAD_HIGH_MIN;
      hi = is_repeat ? LONG_MAX : LEAD_HIGH_MAX;
      if (break_at == 2) begin
         offer_edge(pick_out(lo, hi), 1'b0);
         return;
      end
      offer_edge(pick_in(lo, hi), 1'b0);
      if (!is_repeat) begin
         for (k = 0; k < FRAME_BITS; k++) begin
            // stray rising edge, the data state ignores it
            if ($urandom_range(19) == 0) offer_edge(WIDTH_W'($urandom_range(65535)), 1'b1);
            lo = payload[k] ? LONG_MIN : SHORT_MIN;
            hi = payload[k] ? LONG_MAX : SHORT_MAX;
            if (break_at == k + 3) begin
               offer_edge(pick_out(lo, hi), 1'b0);
               return;
            end
            offer_edge(pick_in(lo, hi), 1'b0);
         end
      end
      offer_edge(WIDTH_W'($urandom_range(65535)), 1'b1);
   endtask

   // unstructured items, now and then a decoder reset
   task automatic send_noise(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0) begin
            offer(REQ_RESET, WIDTH_W'($urandom_range(65535)), 1'($urandom_range(1)),
                  1'b0, QUIET);
         end else begin
            offer_edge(($urandom_range(1) != 0) ? WIDTH_W'($urandom_range(65535))
                                                 : WIDTH_W'($urandom_range(11000)),
                       1'($urandom_range(1)));
         end
      end
   endtask

   task automatic pause_until_drained();
      req_valid = 1'b0;
      while (decoded_frames.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // random stalls, plus one long hold-off when the sender asks for it
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = gaps_on && ($urandom_range(99) < GAP_PERCENT);
         end
      end
   end

   // compare each response transfer with the oldest expectation
   result_type want_now;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_frames.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_frame_data, '0);
         end else begin
            want_now = decoded_frames.pop_front();
            if (rsp_frame_done !== want_now.frame_done)
               report_mismatch("frame_done", rsp_frame_done, want_now.frame_done);
            if (rsp_frame_data !== want_now.frame_data)
               report_mismatch("frame_data", rsp_frame_data, want_now.frame_data);
            if (rsp_format_error !== want_now.format_error)
               report_mismatch("format_error", rsp_format_error, want_now.format_error);
            if (rsp_capture_rising !== want_now.capture_rising)
               report_mismatch("capture_rising", rsp_capture_rising,
                               want_now.capture_rising);
         end
      end
   end

   // hang detector: no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_cycles <= 0;
      end else if (hang_cycles >= HANG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int r;
      int seq_index;
      int k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_EDGE;
      req_pulse_width = '0;
      req_line_level  = 1'b1;
      gaps_on         = 1'b1;
      hold_request    = 1'b0;
      hang_cycles     = 0;
      mismatch_count  = 0;
      edges_sent      = 0;
      ir_state        = ST_IDLE;
      ir_bit_count    = '0;
      ir_word         = '0;
      ir_rising_next  = 1'b0;
      seq_index       = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part: window edges, level mismatches, repeats, errors
      for (k = 0; k < DIRECTED_N; k++) begin
         offer(directed_rows[k].kind, directed_rows[k].width, directed_rows[k].level,
               directed_rows[k].typed, directed_rows[k].want);
      end

      // random part: mostly well-formed frames with random content
      while (edges_sent < ITEM_TARGET) begin
         // a stretch with no idling on either side
         gaps_on = !(seq_index >= 25 && seq_index < 35);
         // long receiver hold-off while frames keep coming
         if (seq_index == 8 || seq_index == 40) hold_request = 1'b1;
         // sender waits for everything outstanding
         if (seq_index == 15 || seq_index == 45) pause_until_drained();
         r = $urandom_range(99);
         if (r < 60)      send_frame(1'b0, 0);
         else if (r < 75) send_frame(1'b1, 0);
         else if (r < 80) send_frame(1'b1, $urandom_range(2, 1));
         else if (r < 90) send_frame(1'b0, $urandom_range(FRAME_BITS + 2, 1));
         else             send_noise($urandom_range(8, 2));
         seq_index++;
      end
      req_valid = 1'b0;

      // drain, then a few more cycles to catch anything extra
      while (decoded_frames.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
